// ===== hdl/ocu_pkg.sv =====
// Shared types, constants and the arctangent table for the orbit camera update unit.
// No dependencies; every other file of the unit imports this package.
`default_nettype none

package ocu_pkg;

    localparam int CORDIC_STAGES_DEF = 20;

    localparam int VEC_W   = 48;
    localparam int ANG_W   = 34;
    localparam int SC_W    = 34;
    localparam int WANG_W  = 38;
    localparam int RAD_W   = 36;
    localparam int STEP_W  = 36;
    localparam int ZOOM_W  = 28;
    localparam int KEY_W   = 6;
    localparam int COORD_W = 32;
    localparam int DT_W    = 17;
    localparam int RLIM_W  = 31;
    localparam int PLIM_W  = 18;
    localparam int ROT_W   = 21;
    localparam int ZSPD_W  = 27;
    localparam int CIDX_W  = 3;
    localparam int CDAT_W  = 32;

    typedef logic signed [VEC_W-1:0]   t_vec;
    typedef logic signed [ANG_W-1:0]   t_ang;
    typedef logic signed [SC_W-1:0]    t_sc;
    typedef logic signed [WANG_W-1:0]  t_wang;
    typedef logic signed [RAD_W-1:0]   t_rad;
    typedef logic signed [COORD_W-1:0] t_coord;

    localparam logic [29:0] GAIN_K      = 30'h26DD3B6A;
    localparam t_ang        HALF_PI_Q30 = 34'sd1686629713;
    localparam longint      PI_L        = 64'sd3373259426;
    localparam longint      TWO_PI_L    = 64'sd6746518852;

    typedef enum logic [CIDX_W-1:0] {
        CFG_ROT_SPEED  = 3'd0,
        CFG_ZOOM_SPEED = 3'd1,
        CFG_PITCH_LO   = 3'd2,
        CFG_PITCH_HI   = 3'd3,
        CFG_RADIUS_LO  = 3'd4,
        CFG_RADIUS_HI  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [ROT_W-1:0]         rotation_speed;
        logic [ZSPD_W-1:0]        zoom_speed;
        logic signed [PLIM_W-1:0] pitch_lower;
        logic signed [PLIM_W-1:0] pitch_upper;
        logic [RLIM_W-1:0]        radius_lower;
        logic [RLIM_W-1:0]        radius_upper;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        rotation_speed: 21'd98304,
        zoom_speed:     27'd9830400,
        pitch_lower:    -18'sd101797,
        pitch_upper:    18'sd101797,
        radius_lower:   31'd131072,
        radius_upper:   31'd131072000
    };

    function automatic t_ang atan_q30(input int idx);
        t_ang v;
        unique case (idx)
            0:  v = 34'sh3243F6A8;
            1:  v = 34'sh1DAC6705;
            2:  v = 34'sh0FADBAFC;
            3:  v = 34'sh07F56EA6;
            4:  v = 34'sh03FEAB76;
            5:  v = 34'sh01FFD55B;
            6:  v = 34'sh00FFFAAA;
            7:  v = 34'sh007FFF55;
            8:  v = 34'sh003FFFEA;
            9:  v = 34'sh001FFFFD;
            10: v = 34'sh000FFFFF;
            11: v = 34'sh0007FFFF;
            12: v = 34'sh0003FFFF;
            13: v = 34'sh0001FFFF;
            14: v = 34'sh0000FFFF;
            15: v = 34'sh00007FFF;
            16: v = 34'sh00003FFF;
            17: v = 34'sh00001FFF;
            18: v = 34'sh00000FFF;
            19: v = 34'sh000007FF;
            20: v = 34'sh000003FF;
            21: v = 34'sh000001FF;
            22: v = 34'sh000000FF;
            23: v = 34'sh0000007F;
            24: v = 34'sh0000003F;
            25: v = 34'sh0000001F;
            26: v = 34'sh0000000F;
            27: v = 34'sh00000008;
            28: v = 34'sh00000004;
            29: v = 34'sh00000002;
            30: v = 34'sh00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ocu_vec.sv =====
// Pipelined CORDIC vectoring unit: angle and gain-corrected magnitude of (x, y).
// One iteration per register stage, then two stages for the gain multiply.
// Depends on ocu_pkg.
`default_nettype none

module ocu_vec #(
    parameter int STAGES = ocu_pkg::CORDIC_STAGES_DEF,
    parameter int SB_W   = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  ocu_pkg::t_vec        i_x,
    input  ocu_pkg::t_vec        i_y,
    input  logic [SB_W-1:0]      i_sb,
    output logic                 o_valid,
    output ocu_pkg::t_ang        o_ang,
    output ocu_pkg::t_vec        o_mag,
    output logic [SB_W-1:0]      o_sb
);
    import ocu_pkg::*;

    t_vec            r_x    [0:STAGES];
    t_vec            r_y    [0:STAGES];
    t_ang            r_z    [0:STAGES];
    logic            r_zero [0:STAGES];
    logic [SB_W-1:0] r_sb   [0:STAGES];
    logic [STAGES+2:0] r_vld;

    t_vec n_x0;
    t_vec n_y0;
    t_ang n_z0;

    logic [VEC_W+13:0] r_hi;
    logic [29:0]       r_lo;
    t_ang              r_g1_ang;
    logic [SB_W-1:0]   r_g1_sb;
    t_vec              r_mag;
    t_ang              r_ang;
    logic [SB_W-1:0]   r_g2_sb;

    logic [VEC_W+13:0]      n_hi_p;
    logic [45:0]            n_lo_p;
    logic [VEC_W+13:0]      n_sum;

    always_comb begin
        n_x0 = i_x;
        n_y0 = i_y;
        n_z0 = '0;
        if (i_x[VEC_W-1]) begin
            if (!i_y[VEC_W-1]) begin
                n_x0 = i_y;
                n_y0 = -i_x;
                n_z0 = HALF_PI_Q30;
            end else begin
                n_x0 = -i_y;
                n_y0 = i_x;
                n_z0 = -HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES+1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            r_sb[0]   <= i_sb;
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[g+1] <= r_zero[g];
                r_sb[g+1]   <= r_sb[g];
                if (!r_y[g][VEC_W-1]) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_q30(g);
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_q30(g);
                end
            end
        end
    end

    assign n_hi_p = (VEC_W+14)'(r_x[STAGES][VEC_W-1:16]) * (VEC_W+14)'(GAIN_K);
    assign n_lo_p = 46'(r_x[STAGES][15:0]) * 46'(GAIN_K);
    assign n_sum  = r_hi + (VEC_W+14)'(r_lo);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hi     <= n_hi_p;
            r_lo     <= n_lo_p[45:16];
            r_g1_ang <= r_zero[STAGES] ? '0 : r_z[STAGES];
            r_g1_sb  <= r_sb[STAGES];
            r_mag    <= n_sum[VEC_W+13:14];
            r_ang    <= r_g1_ang;
            r_g2_sb  <= r_g1_sb;
        end
    end

    assign o_valid = r_vld[STAGES+2];
    assign o_ang   = r_ang;
    assign o_mag   = r_mag;
    assign o_sb    = r_g2_sb;

endmodule

`default_nettype wire

// ===== hdl/ocu_adjust.sv =====
// Key steps, pitch and radius clamps and yaw reduction to [-pi, pi], five stages.
// Depends on ocu_pkg.
`default_nettype none

module ocu_adjust #(
    parameter int SB_W = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  ocu_pkg::t_ang                i_yaw,
    input  ocu_pkg::t_ang                i_pitch,
    input  ocu_pkg::t_vec                i_r24,
    input  logic [ocu_pkg::STEP_W-1:0]   i_step,
    input  logic [ocu_pkg::ZOOM_W-1:0]   i_zoom,
    input  logic [ocu_pkg::KEY_W-1:0]    i_keys,
    input  ocu_pkg::t_cfg                i_cfg,
    input  logic [SB_W-1:0]              i_sb,
    output logic                         o_valid,
    output ocu_pkg::t_ang                o_yaw,
    output ocu_pkg::t_ang                o_pitch,
    output logic [ocu_pkg::RLIM_W-1:0]   o_radius,
    output logic [SB_W-1:0]              o_sb
);
    import ocu_pkg::*;

    localparam int MAG_W = WANG_W - 1;
    localparam logic [MAG_W-1:0] TP1 = MAG_W'(TWO_PI_L);
    localparam logic [MAG_W-1:0] TP2 = MAG_W'(TWO_PI_L * 2);
    localparam logic [MAG_W-1:0] TP4 = MAG_W'(TWO_PI_L * 4);
    localparam logic [MAG_W-1:0] TP8 = MAG_W'(TWO_PI_L * 8);
    localparam t_wang PI_W  = WANG_W'(PI_L);
    localparam t_wang TPI_W = WANG_W'(TWO_PI_L);

    logic [4:0] r_vld;

    t_wang r_a_yaw, r_a_pitch;
    t_rad  r_a_rad;
    logic [SB_W-1:0] r_a_sb, r_b_sb, r_c_sb, r_d_sb, r_e_sb;

    logic [MAG_W-1:0] r_b_mag, r_c_mag, r_d_mag;
    logic             r_b_neg, r_c_neg, r_d_neg;
    t_ang             r_b_pitch, r_c_pitch, r_d_pitch, r_e_pitch;
    logic [RLIM_W-1:0] r_b_rad, r_c_rad, r_d_rad, r_e_rad;
    t_ang             r_e_yaw;

    t_wang n_yaw, n_pitch, n_plo, n_phi, n_pcl, n_fold;
    t_rad  n_rad, n_rcl, n_rlo, n_rhi;
    t_vec  n_rr;
    t_wang n_step;
    logic [MAG_W-1:0] n_c_mag, n_d_mag;

    always_comb begin
        n_step = WANG_W'(i_step);
        n_yaw  = WANG_W'(i_yaw);
        n_pitch = WANG_W'(i_pitch);
        n_rr   = (i_r24 + t_vec'(128)) >>> 8;
        n_rad  = RAD_W'(n_rr);
        if (i_keys[0]) n_yaw = n_yaw - n_step;
        if (i_keys[1]) n_yaw = n_yaw + n_step;
        if (i_keys[2]) n_pitch = n_pitch + n_step;
        if (i_keys[3]) n_pitch = n_pitch - n_step;
        if (i_keys[4]) n_rad = n_rad - RAD_W'(i_zoom);
        if (i_keys[5]) n_rad = n_rad + RAD_W'(i_zoom);
    end

    always_comb begin
        n_plo = WANG_W'($signed({i_cfg.pitch_lower, 14'b0}));
        n_phi = WANG_W'($signed({i_cfg.pitch_upper, 14'b0}));
        n_rlo = $signed(RAD_W'(i_cfg.radius_lower));
        n_rhi = $signed(RAD_W'(i_cfg.radius_upper));
        n_pcl = r_a_pitch;
        if (n_pcl < n_plo) n_pcl = n_plo;
        if (n_pcl > n_phi) n_pcl = n_phi;
        n_rcl = r_a_rad;
        if (n_rcl < n_rlo) n_rcl = n_rlo;
        if (n_rcl > n_rhi) n_rcl = n_rhi;
    end

    always_comb begin
        n_c_mag = r_b_mag;
        if (n_c_mag >= TP8) n_c_mag = n_c_mag - TP8;
        if (n_c_mag >= TP4) n_c_mag = n_c_mag - TP4;
        n_d_mag = r_c_mag;
        if (n_d_mag >= TP2) n_d_mag = n_d_mag - TP2;
        if (n_d_mag >= TP1) n_d_mag = n_d_mag - TP1;
        n_fold = r_d_neg ? -t_wang'({1'b0, r_d_mag}) : t_wang'({1'b0, r_d_mag});
        if (n_fold > PI_W) n_fold = n_fold - TPI_W;
        if (n_fold < -PI_W) n_fold = n_fold + TPI_W;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_yaw   <= n_yaw;
            r_a_pitch <= n_pitch;
            r_a_rad   <= n_rad;
            r_a_sb    <= i_sb;

            r_b_neg   <= r_a_yaw[WANG_W-1];
            r_b_mag   <= r_a_yaw[WANG_W-1] ? MAG_W'(-r_a_yaw) : MAG_W'(r_a_yaw);
            r_b_pitch <= ANG_W'(n_pcl);
            r_b_rad   <= RLIM_W'(n_rcl);
            r_b_sb    <= r_a_sb;

            r_c_mag   <= n_c_mag;
            r_c_neg   <= r_b_neg;
            r_c_pitch <= r_b_pitch;
            r_c_rad   <= r_b_rad;
            r_c_sb    <= r_b_sb;

            r_d_mag   <= n_d_mag;
            r_d_neg   <= r_c_neg;
            r_d_pitch <= r_c_pitch;
            r_d_rad   <= r_c_rad;
            r_d_sb    <= r_c_sb;

            r_e_yaw   <= ANG_W'(n_fold);
            r_e_pitch <= r_d_pitch;
            r_e_rad   <= r_d_rad;
            r_e_sb    <= r_d_sb;
        end
    end

    assign o_valid  = r_vld[4];
    assign o_yaw    = r_e_yaw;
    assign o_pitch  = r_e_pitch;
    assign o_radius = r_e_rad;
    assign o_sb     = r_e_sb;

endmodule

`default_nettype wire

// ===== hdl/ocu_rot.sv =====
// Two-lane pipelined CORDIC rotation unit: cosine and sine of yaw and pitch, Q30.
// One iteration per register stage after a quadrant stage. Depends on ocu_pkg.
`default_nettype none

module ocu_rot #(
    parameter int STAGES = ocu_pkg::CORDIC_STAGES_DEF,
    parameter int SB_W   = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  ocu_pkg::t_ang     i_z   [2],
    input  logic [SB_W-1:0]   i_sb,
    output logic              o_valid,
    output ocu_pkg::t_sc      o_cos [2],
    output ocu_pkg::t_sc      o_sin [2],
    output logic [SB_W-1:0]   o_sb
);
    import ocu_pkg::*;

    localparam t_sc K_SC = SC_W'(GAIN_K);

    t_sc  r_x [2][0:STAGES];
    t_sc  r_y [2][0:STAGES];
    t_ang r_z [2][0:STAGES];
    logic [SB_W-1:0] r_sb [0:STAGES];
    logic [STAGES:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sb[0] <= i_sb;
        end
    end

    for (genvar s = 0; s < STAGES; s++) begin : g_sb
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sb[s+1] <= r_sb[s];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (i_z[l] > HALF_PI_Q30) begin
                    r_x[l][0] <= '0;
                    r_y[l][0] <= K_SC;
                    r_z[l][0] <= i_z[l] - HALF_PI_Q30;
                end else if (i_z[l] < -HALF_PI_Q30) begin
                    r_x[l][0] <= '0;
                    r_y[l][0] <= -K_SC;
                    r_z[l][0] <= i_z[l] + HALF_PI_Q30;
                end else begin
                    r_x[l][0] <= K_SC;
                    r_y[l][0] <= '0;
                    r_z[l][0] <= i_z[l];
                end
            end
        end

        for (genvar g = 0; g < STAGES; g++) begin : g_iter
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!r_z[l][g][ANG_W-1]) begin
                        r_x[l][g+1] <= r_x[l][g] - (r_y[l][g] >>> g);
                        r_y[l][g+1] <= r_y[l][g] + (r_x[l][g] >>> g);
                        r_z[l][g+1] <= r_z[l][g] - atan_q30(g);
                    end else begin
                        r_x[l][g+1] <= r_x[l][g] + (r_y[l][g] >>> g);
                        r_y[l][g+1] <= r_y[l][g] - (r_x[l][g] >>> g);
                        r_z[l][g+1] <= r_z[l][g] + atan_q30(g);
                    end
                end
            end
        end

        assign o_cos[l] = r_x[l][STAGES];
        assign o_sin[l] = r_y[l][STAGES];
    end

    assign o_valid = r_vld[STAGES];
    assign o_sb    = r_sb[STAGES];

endmodule

`default_nettype wire

// ===== hdl/orbit_camera_update_unit.sv =====
// Orbit camera update unit: spherical step of a camera position about a target.
// Accepts one beat per cycle while the output is not stalled, set by one CORDIC
// iteration per register stage. A stalled output freezes the whole pipe.
// Synchronous active-low reset clears valid bits and loads register defaults.
// Depends on ocu_pkg, ocu_vec, ocu_adjust and ocu_rot.
`default_nettype none

module orbit_camera_update_unit #(
    parameter int CORDIC_STAGES = ocu_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ocu_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [ocu_pkg::CDAT_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [31:0]            i_pos_x,
    input  logic signed [31:0]            i_pos_y,
    input  logic signed [31:0]            i_pos_z,
    input  logic signed [31:0]            i_tgt_x,
    input  logic signed [31:0]            i_tgt_y,
    input  logic signed [31:0]            i_tgt_z,
    input  logic [ocu_pkg::DT_W-1:0]      i_delta_time,
    input  logic [ocu_pkg::KEY_W-1:0]     i_key_mask,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [31:0]            o_new_x,
    output logic signed [31:0]            o_new_y,
    output logic signed [31:0]            o_new_z
);
    import ocu_pkg::*;

    localparam int TGT_W = 3 * COORD_W;
    localparam int D_W   = COORD_W + 1;
    localparam int SB1_W = TGT_W + D_W + STEP_W + ZOOM_W + KEY_W;
    localparam int SB2_W = TGT_W + STEP_W + ZOOM_W + KEY_W + ANG_W;
    localparam int SBR_W = TGT_W + RLIM_W;

    function automatic t_coord sat32(input logic signed [39:0] v);
        t_coord r;
        if (v > 40'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -40'sd2147483648) r = 32'sh80000000;
        else r = COORD_W'(v);
        return r;
    endfunction

    t_cfg r_cfg;
    logic en;
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ROT_SPEED:  r_cfg.rotation_speed <= i_cfg_data[ROT_W-1:0];
                CFG_ZOOM_SPEED: r_cfg.zoom_speed     <= i_cfg_data[ZSPD_W-1:0];
                CFG_PITCH_LO:   r_cfg.pitch_lower    <= $signed(i_cfg_data[PLIM_W-1:0]);
                CFG_PITCH_HI:   r_cfg.pitch_upper    <= $signed(i_cfg_data[PLIM_W-1:0]);
                CFG_RADIUS_LO:  r_cfg.radius_lower   <= i_cfg_data[RLIM_W-1:0];
                CFG_RADIUS_HI:  r_cfg.radius_upper   <= i_cfg_data[RLIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // input stage
    logic                     r_s0_vld;
    logic signed [D_W-1:0]    r_dx, r_dy, r_dz;
    logic [TGT_W-1:0]         r_s0_tgt;
    logic [STEP_W-1:0]        r_step;
    logic [ZOOM_W-1:0]        r_zoom;
    logic [KEY_W-1:0]         r_keys;
    logic [ROT_W+DT_W-1:0]    n_rot_p;
    logic [ZSPD_W+DT_W-1:0]   n_zoom_p;

    assign n_rot_p  = (ROT_W+DT_W)'(r_cfg.rotation_speed) * (ROT_W+DT_W)'(i_delta_time);
    assign n_zoom_p = (ZSPD_W+DT_W)'(r_cfg.zoom_speed) * (ZSPD_W+DT_W)'(i_delta_time);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx     <= D_W'(i_pos_x) - D_W'(i_tgt_x);
            r_dy     <= D_W'(i_pos_y) - D_W'(i_tgt_y);
            r_dz     <= D_W'(i_pos_z) - D_W'(i_tgt_z);
            r_s0_tgt <= {i_tgt_x, i_tgt_y, i_tgt_z};
            r_step   <= n_rot_p[ROT_W+DT_W-1:2];
            r_zoom   <= n_zoom_p[ZSPD_W+DT_W-1:16];
            r_keys   <= i_key_mask;
        end
    end

    // yaw and horizontal length
    logic             v1_vld;
    t_ang             v1_ang;
    t_vec             v1_mag;
    logic [SB1_W-1:0] v1_sb;

    ocu_vec #(.STAGES(CORDIC_STAGES), .SB_W(SB1_W)) u_vec_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s0_vld),
        .i_x     (t_vec'($signed({r_dz, 8'b0}))),
        .i_y     (t_vec'($signed({r_dx, 8'b0}))),
        .i_sb    ({r_s0_tgt, r_dy, r_step, r_zoom, r_keys}),
        .o_valid (v1_vld),
        .o_ang   (v1_ang),
        .o_mag   (v1_mag),
        .o_sb    (v1_sb)
    );

    logic [TGT_W-1:0]      v1_tgt;
    logic signed [D_W-1:0] v1_dy;
    logic [STEP_W-1:0]     v1_step;
    logic [ZOOM_W-1:0]     v1_zoom;
    logic [KEY_W-1:0]      v1_keys;

    assign {v1_tgt, v1_dy, v1_step, v1_zoom, v1_keys} = v1_sb;

    // pitch and radius
    logic             v2_vld;
    t_ang             v2_ang;
    t_vec             v2_mag;
    logic [SB2_W-1:0] v2_sb;

    ocu_vec #(.STAGES(CORDIC_STAGES), .SB_W(SB2_W)) u_vec_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v1_vld),
        .i_x     (v1_mag),
        .i_y     (t_vec'($signed({v1_dy, 8'b0}))),
        .i_sb    ({v1_tgt, v1_step, v1_zoom, v1_keys, v1_ang}),
        .o_valid (v2_vld),
        .o_ang   (v2_ang),
        .o_mag   (v2_mag),
        .o_sb    (v2_sb)
    );

    logic [TGT_W-1:0]  v2_tgt;
    logic [STEP_W-1:0] v2_step;
    logic [ZOOM_W-1:0] v2_zoom;
    logic [KEY_W-1:0]  v2_keys;
    t_ang              v2_yaw;

    assign {v2_tgt, v2_step, v2_zoom, v2_keys, v2_yaw} = v2_sb;

    logic              ad_vld;
    t_ang              ad_yaw, ad_pitch;
    logic [RLIM_W-1:0] ad_rad;
    logic [TGT_W-1:0]  ad_tgt;

    ocu_adjust #(.SB_W(TGT_W)) u_adjust (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (v2_vld),
        .i_yaw    (v2_yaw),
        .i_pitch  (v2_ang),
        .i_r24    (v2_mag),
        .i_step   (v2_step),
        .i_zoom   (v2_zoom),
        .i_keys   (v2_keys),
        .i_cfg    (r_cfg),
        .i_sb     (v2_tgt),
        .o_valid  (ad_vld),
        .o_yaw    (ad_yaw),
        .o_pitch  (ad_pitch),
        .o_radius (ad_rad),
        .o_sb     (ad_tgt)
    );

    // lane 0 yaw, lane 1 pitch
    t_ang             rot_z   [2];
    t_sc              rot_cos [2];
    t_sc              rot_sin [2];
    logic             rot_vld;
    logic [SBR_W-1:0] rot_sb;

    assign rot_z[0] = ad_yaw;
    assign rot_z[1] = ad_pitch;

    ocu_rot #(.STAGES(CORDIC_STAGES), .SB_W(SBR_W)) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ad_vld),
        .i_z     (rot_z),
        .i_sb    ({ad_tgt, ad_rad}),
        .o_valid (rot_vld),
        .o_cos   (rot_cos),
        .o_sin   (rot_sin),
        .o_sb    (rot_sb)
    );

    logic [TGT_W-1:0]  rot_tgt;
    logic [RLIM_W-1:0] rot_rad;

    assign {rot_tgt, rot_rad} = rot_sb;

    // output multiplies
    logic [2:0] r_m_vld;
    logic signed [63:0] r_m1_pc, r_m1_ps;
    t_coord r_m1_cy, r_m1_sy;
    logic [TGT_W-1:0] r_m1_tgt;

    logic signed [33:0] r_m2_rc;
    t_coord r_m2_cy, r_m2_sy, r_m2_ny, r_m2_tx, r_m2_tz;

    logic signed [65:0] r_m3_px, r_m3_pz;
    t_coord r_m3_ny, r_m3_tx, r_m3_tz;

    t_coord r_out_x, r_out_y, r_out_z;

    logic signed [63:0] n_rc_t, n_ps_t;
    logic signed [65:0] n_px_t, n_pz_t;

    assign n_rc_t = (r_m1_pc + 64'sd536870912) >>> 30;
    assign n_ps_t = (r_m1_ps + 64'sd536870912) >>> 30;
    assign n_px_t = (r_m3_px + 66'sd536870912) >>> 30;
    assign n_pz_t = (r_m3_pz + 66'sd536870912) >>> 30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld     <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_m_vld     <= {r_m_vld[1:0], rot_vld};
            r_out_valid <= r_m_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_pc  <= 64'($signed({1'b0, rot_rad})) * 64'($signed(rot_cos[1][31:0]));
            r_m1_ps  <= 64'($signed({1'b0, rot_rad})) * 64'($signed(rot_sin[1][31:0]));
            r_m1_cy  <= rot_cos[0][31:0];
            r_m1_sy  <= rot_sin[0][31:0];
            r_m1_tgt <= rot_tgt;

            r_m2_rc  <= 34'(n_rc_t);
            r_m2_cy  <= r_m1_cy;
            r_m2_sy  <= r_m1_sy;
            r_m2_ny  <= sat32(40'($signed(n_ps_t[35:0]))
                              + 40'($signed(r_m1_tgt[2*COORD_W-1:COORD_W])));
            r_m2_tx  <= r_m1_tgt[3*COORD_W-1:2*COORD_W];
            r_m2_tz  <= r_m1_tgt[COORD_W-1:0];

            r_m3_px  <= 66'(r_m2_rc) * 66'(r_m2_sy);
            r_m3_pz  <= 66'(r_m2_rc) * 66'(r_m2_cy);
            r_m3_ny  <= r_m2_ny;
            r_m3_tx  <= r_m2_tx;
            r_m3_tz  <= r_m2_tz;

            r_out_x  <= sat32(40'($signed(n_px_t[36:0])) + 40'(r_m3_tx));
            r_out_y  <= r_m3_ny;
            r_out_z  <= sat32(40'($signed(n_pz_t[36:0])) + 40'(r_m3_tz));
        end
    end

    assign o_valid = r_out_valid;
    assign o_new_x = r_out_x;
    assign o_new_y = r_out_y;
    assign o_new_z = r_out_z;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for orbit_camera_update_unit: directed and random camera updates
// across several register settings, checked against an in-bench fixed-point CORDIC predictor.
// Depends on ocu_pkg and the orbit_camera_update_unit RTL.
`timescale 1ns / 1ps

module tb_top;
    import ocu_pkg::*;

    localparam int          STAGES     = 20;
    localparam int          DRAIN_CYC  = 3 * STAGES + 40;
    localparam logic [2:0]  CFG_NONE   = 3'd7;
    localparam logic [2:0]  CFG_SPARE  = 3'd6;
    localparam logic [5:0]  KEY_YAW_MINUS   = 6'h01;
    localparam logic [5:0]  KEY_YAW_PLUS    = 6'h02;
    localparam logic [5:0]  KEY_PITCH_PLUS  = 6'h04;
    localparam logic [5:0]  KEY_PITCH_MINUS = 6'h08;
    localparam logic [5:0]  KEY_ZOOM_IN     = 6'h10;
    localparam logic [5:0]  KEY_ZOOM_OUT    = 6'h20;
    localparam longint      ATAN_TBL [20] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF
    };

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_pos;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CIDX_W-1:0]  i_cfg_index;
    logic [CDAT_W-1:0]  i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [31:0] i_tgt_x, i_tgt_y, i_tgt_z;
    logic [DT_W-1:0]    i_delta_time;
    logic [KEY_W-1:0]   i_key_mask;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_new_x, o_new_y, o_new_z;

    t_cfg   shadow_cfg;
    t_pos   expected_pos [$];
    int     error_count;
    bit     idle_on;
    int     stall_left;

    orbit_camera_update_unit u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    function automatic void vec_polar(input longint x0, input longint y0,
                                      output longint ang, output longint mag);
        longint x, y, z, t, nx, ny;
        longint unsigned u, hi, lo;
        x = x0;
        y = y0;
        z = 0;
        if (x == 0 && y == 0) begin
            ang = 0;
            mag = 0;
            return;
        end
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = longint'(HALF_PI_Q30);
            end else begin
                t = x; x = -y; y = t; z = -longint'(HALF_PI_Q30);
            end
        end
        for (int i = 0; i < STAGES; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_TBL[i];
            end else begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_TBL[i];
            end
            x = nx;
            y = ny;
        end
        ang = z;
        u   = x;
        hi  = (u >> 16) * longint'(GAIN_K);
        lo  = ((u & 64'hFFFF) * longint'(GAIN_K)) >> 16;
        mag = longint'((hi + lo) >> 14);
    endfunction

    function automatic void sin_cos_q30(input longint ang, output longint c, output longint s);
        longint x, y, z, nx, ny;
        x = longint'(GAIN_K);
        y = 0;
        z = ang;
        if (z > longint'(HALF_PI_Q30)) begin
            x = 0; y = longint'(GAIN_K); z -= longint'(HALF_PI_Q30);
        end else if (z < -longint'(HALF_PI_Q30)) begin
            x = 0; y = -longint'(GAIN_K); z += longint'(HALF_PI_Q30);
        end
        for (int i = 0; i < STAGES; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_TBL[i];
            end else begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_TBL[i];
            end
            x = nx;
            y = ny;
        end
        c = x;
        s = y;
    endfunction

    function automatic longint round_q30(input longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic t_pos orbit_step(input logic signed [31:0] px, py, pz, tx, ty, tz,
                                        input logic [DT_W-1:0] dt, input logic [KEY_W-1:0] keys);
        longint dx, dy, dz, yaw, pitch, h, r24, radius, step, zoom, lim;
        longint cy, sy, cp, sp, rc;
        t_pos   r;
        dx = longint'(px) - longint'(tx);
        dy = longint'(py) - longint'(ty);
        dz = longint'(pz) - longint'(tz);
        vec_polar(dz * 256, dx * 256, yaw, h);
        vec_polar(h, dy * 256, pitch, r24);
        radius = (r24 + 128) >>> 8;
        step = (longint'(shadow_cfg.rotation_speed) * longint'(dt)) >>> 2;
        zoom = (longint'(shadow_cfg.zoom_speed) * longint'(dt)) >>> 16;
        if (keys & KEY_YAW_MINUS)   yaw    -= step;
        if (keys & KEY_YAW_PLUS)    yaw    += step;
        if (keys & KEY_PITCH_PLUS)  pitch  += step;
        if (keys & KEY_PITCH_MINUS) pitch  -= step;
        if (keys & KEY_ZOOM_IN)     radius -= zoom;
        if (keys & KEY_ZOOM_OUT)    radius += zoom;
        lim = longint'(shadow_cfg.pitch_lower) * 16384;
        if (pitch < lim) pitch = lim;
        lim = longint'(shadow_cfg.pitch_upper) * 16384;
        if (pitch > lim) pitch = lim;
        if (radius < longint'(shadow_cfg.radius_lower)) radius = longint'(shadow_cfg.radius_lower);
        if (radius > longint'(shadow_cfg.radius_upper)) radius = longint'(shadow_cfg.radius_upper);
        yaw = yaw % TWO_PI_L;
        if (yaw > PI_L)  yaw -= TWO_PI_L;
        if (yaw < -PI_L) yaw += TWO_PI_L;
        sin_cos_q30(yaw, cy, sy);
        sin_cos_q30(pitch, cp, sp);
        rc = round_q30(radius * cp);
        r.x = clip32(longint'(tx) + round_q30(rc * sy));
        r.y = clip32(longint'(ty) + round_q30(radius * sp));
        r.z = clip32(longint'(tz) + round_q30(rc * cy));
        return r;
    endfunction

    // Result checker and output stall generator.
    always @(posedge i_clk) begin
        t_pos e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pos.size() == 0) begin
                $display("%0t: unexpected beat x=%0d y=%0d z=%0d", $time, o_new_x, o_new_y,
                         o_new_z);
                error_count++;
            end else begin
                e = expected_pos.pop_front();
                if (o_new_x !== e.x) begin
                    $display("%0t: new_x expected %0d actual %0d", $time, e.x, o_new_x);
                    error_count++;
                end
                if (o_new_y !== e.y) begin
                    $display("%0t: new_y expected %0d actual %0d", $time, e.y, o_new_y);
                    error_count++;
                end
                if (o_new_z !== e.z) begin
                    $display("%0t: new_z expected %0d actual %0d", $time, e.z, o_new_z);
                    error_count++;
                end
            end
            stall_left = idle_on ? $urandom_range(0, 17) : 0;
        end
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_update(input logic signed [31:0] px, py, pz, tx, ty, tz,
                               input logic [DT_W-1:0] dt, input logic [KEY_W-1:0] keys);
        int gap;
        gap = idle_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_pos_x      <= px;
        i_pos_y      <= py;
        i_pos_z      <= pz;
        i_tgt_x      <= tx;
        i_tgt_y      <= ty;
        i_tgt_z      <= tz;
        i_delta_time <= dt;
        i_key_mask   <= keys;
        do @(posedge i_clk); while (o_stall);
        expected_pos.push_back(orbit_step(px, py, pz, tx, ty, tz, dt, keys));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pos.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ROT_SPEED:  shadow_cfg.rotation_speed = data[ROT_W-1:0];
            CFG_ZOOM_SPEED: shadow_cfg.zoom_speed     = data[ZSPD_W-1:0];
            CFG_PITCH_LO:   shadow_cfg.pitch_lower    = data[PLIM_W-1:0];
            CFG_PITCH_HI:   shadow_cfg.pitch_upper    = data[PLIM_W-1:0];
            CFG_RADIUS_LO:  shadow_cfg.radius_lower   = data[RLIM_W-1:0];
            CFG_RADIUS_HI:  shadow_cfg.radius_upper   = data[RLIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_regs(input logic [CDAT_W-1:0] rot, zsp, plo, phi, rlo, rhi);
        wait_idle();
        write_reg(CFG_ROT_SPEED, rot);
        write_reg(CFG_ZOOM_SPEED, zsp);
        write_reg(CFG_PITCH_LO, plo);
        write_reg(CFG_PITCH_HI, phi);
        write_reg(CFG_RADIUS_LO, rlo);
        write_reg(CFG_RADIUS_HI, rhi);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h001FFFFF)) - 32'sh00100000;
            2: return $signed($urandom_range(0, 32'h0FFFFFFF)) - 32'sh08000000;
            3: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000;
        endcase
    endfunction

    task automatic test_directed();
        logic [5:0] key_list [10] = '{KEY_YAW_MINUS, KEY_YAW_PLUS, KEY_PITCH_PLUS,
            KEY_PITCH_MINUS, KEY_ZOOM_IN, KEY_ZOOM_OUT, KEY_YAW_MINUS | KEY_YAW_PLUS,
            KEY_PITCH_PLUS | KEY_PITCH_MINUS, KEY_ZOOM_IN | KEY_ZOOM_OUT, 6'h3F};
        idle_on = 1'b0;
        send_update(0, 0, 0, 0, 0, 0, 0, 0);
        send_update(0, 0, 0, 0, 0, 0, 17'd65536, 6'h3F);
        send_update(32'sd100, 32'sd5000000, 32'sd100, 32'sd100, 0, 32'sd100, 17'd1000, 0);
        send_update(0, -32'sd5000000, 0, 0, 0, 0, 17'd65536, KEY_PITCH_MINUS);
        send_update(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                    32'sh80000000, 32'sh80000000, 32'sh80000000, 17'd65536, KEY_ZOOM_OUT);
        send_update(32'sh80000000, 32'sh80000000, 32'sh80000000,
                    32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 17'h1FFFF, 6'h3F);
        send_update(32'sd300000, 0, -32'sd900000, 0, 0, 0, 17'd30000, KEY_YAW_PLUS);
        send_update(-32'sd300000, 0, -32'sd900000, 0, 0, 0, 17'd30000, KEY_YAW_MINUS);
        send_update(0, 32'sd9000000, 32'sd10, 0, 0, 0, 17'd65536, KEY_PITCH_PLUS);
        for (int k = 0; k < 10; k++)
            send_update(32'sd655360, 32'sd327680, 32'sd655360, 32'sd65536, -32'sd65536, 0,
                        17'd8192, key_list[k]);
        idle_on = 1'b1;
        for (int k = 0; k < 6; k++)
            send_update(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), 17'($urandom_range(0, 65536)), 6'(1 << k));
    endtask

    task automatic test_random(input int count);
        logic signed [31:0] tx, ty, tz;
        logic [DT_W-1:0]    dt;
        for (int n = 0; n < count; n++) begin
            if (n % 150 == 0) idle_on = $urandom_range(0, 2) != 0;
            tx = rand_coord();
            ty = rand_coord();
            tz = rand_coord();
            case ($urandom_range(0, 3))
                0: dt = $urandom_range(0, 1) ? 17'd65536 : 17'd0;
                1: dt = 17'($urandom());
                default: dt = 17'($urandom_range(0, 65536));
            endcase
            if ($urandom_range(0, 3) != 0)
                send_update(tx + ($signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000),
                            ty + ($signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000),
                            tz + ($signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000),
                            tx, ty, tz, dt, 6'($urandom_range(0, 63)));
            else
                send_update(rand_coord(), rand_coord(), rand_coord(), tx, ty, tz, dt,
                            6'($urandom_range(0, 63)));
        end
    endtask

    task automatic test_register_sweep();
        load_regs(32'h001FFFFF, 32'h07FFFFFF, 32'h0001921F, -32'sd102943,
                  32'h7FFFFFFF, 32'h7FFFFFFF);
        test_random(250);
        load_regs(0, 0, -32'sd102943, 32'sd102943, 0, 32'h7FFFFFFF);
        test_random(250);
        load_regs(32'd1048576, 32'd67108864, 32'sd102943, -32'sd102943,
                  32'd131072000, 32'd131072);
        test_random(250);
        load_regs(32'hFFE00000 | 32'd65536, 32'hF8000000 | 32'd655360, 32'd0, 32'd0,
                  32'd65536, 32'd6553600);
        write_reg(CFG_NONE, 32'hFFFFFFFF);
        write_reg(CFG_SPARE, 32'h00000000);
        test_random(250);
        load_regs($urandom_range(0, 32'h1FFFFF), $urandom_range(0, 32'h7FFFFFF),
                  -$urandom_range(0, 102943), $urandom_range(0, 102943),
                  $urandom_range(0, 32'h00FFFFFF), $urandom_range(32'h01000000, 32'h7FFFFFFF));
        test_random(250);
        load_regs(32'd98304, 32'd9830400, -32'sd101797, 32'sd101797, 32'd131072, 32'd131072000);
    endtask

    initial begin
        error_count  = 0;
        idle_on      = 1'b0;
        stall_left   = 0;
        shadow_cfg   = CFG_RESET;
        i_rst_n      = 1'b0;
        i_stall      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_pos_x      = '0;
        i_pos_y      = '0;
        i_pos_z      = '0;
        i_tgt_x      = '0;
        i_tgt_y      = '0;
        i_tgt_z      = '0;
        i_delta_time = '0;
        i_key_mask   = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(250);
        test_register_sweep();
        test_random(250);
        wait_idle();
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== orbit_camera_update_unit.f =====
hdl/ocu_pkg.sv
hdl/ocu_vec.sv
hdl/ocu_adjust.sv
hdl/ocu_rot.sv
hdl/orbit_camera_update_unit.sv
test/tb_top.sv
